// File: rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
package deq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_QUERY      = 3'd5
  } req_type_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
    logic fetch;
    logic ok;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic multi;
  } status_t;

endpackage

// File: rtl/double_ended_queue_core.sv
// double-ended queue top level: controller plus datapath
// timing: push, clear, query, failed requests and pops that empty the queue give a result
// beat the cycle after acceptance; other pops first read the new end value from memory
// throughput: one request per cycle unless the result stalls or a pop read is pending
// reset: asynchronous, active low; the queue comes up empty, slot contents stay undefined
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [deq_pkg::REQ_W-1:0]     req_type_i,
  input  logic [deq_pkg::VALUE_W-1:0]   push_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [deq_pkg::VALUE_W-1:0]   front_value_o,
  output logic [deq_pkg::VALUE_W-1:0]   back_value_o,
  output logic [deq_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                          is_empty_o
);
  import deq_pkg::*;

  // command and status between the sequencer and the storage side
  cmd_t    cmd;
  status_t status;

  // the controller decides success from the full and empty flags, and holds
  // off new requests while a pop waits for its memory read or while the
  // result register is stalled
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // the datapath keeps both end values in registers so only a pop that
  // exposes a new end entry needs a memory read
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .push_value_i  (push_value_i),
    .ok_o          (ok_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

// File: rtl/deq_ctrl.sv
// request decode, handshake and sequencing for the double-ended queue
module deq_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [deq_pkg::REQ_W-1:0]       req_type_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  deq_pkg::status_t                status_i,
  output deq_pkg::cmd_t                   cmd_o
);
  import deq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_busy;

  assign out_busy    = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = out_busy;
        if (in_valid_i && !out_busy) begin
          cmd_o.accept = 1'b1;
          case (req_type_e'(req_type_i))
            REQ_PUSH_FRONT: begin
              if (!status_i.full) begin
                cmd_o.push_front = 1'b1;
                cmd_o.ok         = 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (!status_i.full) begin
                cmd_o.push_back = 1'b1;
                cmd_o.ok        = 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (!status_i.empty) begin
                cmd_o.pop_front = 1'b1;
                cmd_o.ok        = 1'b1;
              end
            end
            REQ_POP_BACK: begin
              if (!status_i.empty) begin
                cmd_o.pop_back = 1'b1;
                cmd_o.ok       = 1'b1;
              end
            end
            REQ_CLEAR: begin
              cmd_o.clear = 1'b1;
              cmd_o.ok    = 1'b1;
            end
            REQ_QUERY: begin
              cmd_o.ok = 1'b1;
            end
            default: begin
              cmd_o.ok = 1'b0;
            end
          endcase
          // a pop that leaves entries waits in the fetch state for the new end value
          cmd_o.load_out = !((cmd_o.pop_front || cmd_o.pop_back) && status_i.multi);
        end
      end
      ST_FETCH: begin
        cmd_o.fetch    = 1'b1;
        cmd_o.ok       = 1'b1;
        cmd_o.load_out = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && !cmd_o.load_out) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_busy || cmd_o.load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_fetch_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |=> state_q == ST_IDLE)
    else $error("fetch state held longer than one cycle");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |-> !cmd_o.load_out)
    else $error("result register overwritten while stalled");

  a_fetch_follows_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> $past(cmd_o.pop_front || cmd_o.pop_back))
    else $error("fetch without a preceding pop");
`endif

endmodule

// File: rtl/deq_datapath.sv
// slot memory, end indexes, entry count, end value caches and result register
module deq_datapath #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  deq_pkg::cmd_t                 cmd_i,
  output deq_pkg::status_t              status_o,
  input  logic [deq_pkg::VALUE_W-1:0]   push_value_i,
  output logic                          ok_o,
  output logic [deq_pkg::VALUE_W-1:0]   front_value_o,
  output logic [deq_pkg::VALUE_W-1:0]   back_value_o,
  output logic [deq_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                          is_empty_o
);
  import deq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IDX_W-1:0]      front_idx_q, front_idx_d;
  logic [IDX_W-1:0]      back_idx_q, back_idx_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] front_val_q, front_val_d;
  logic [DATA_WIDTH-1:0] back_val_q, back_val_d;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  fetch_back_q, fetch_back_d;

  logic                  ok_q;
  logic [VALUE_W-1:0]    out_front_q, out_back_q;
  logic [COUNT_W-1:0]    out_cnt_q;
  logic                  out_empty_q;

  logic [IDX_W-1:0]      front_inc, front_dec, back_inc, back_dec;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic                  wr_en, rd_en;
  logic [DATA_WIDTH-1:0] push_val;
  logic                  empty_d;

  assign push_val  = DATA_WIDTH'(push_value_i);
  assign front_inc = (front_idx_q == LAST_IDX) ? '0 : front_idx_q + 1'b1;
  assign front_dec = (front_idx_q == '0) ? LAST_IDX : front_idx_q - 1'b1;
  assign back_inc  = (back_idx_q == LAST_IDX) ? '0 : back_idx_q + 1'b1;
  assign back_dec  = (back_idx_q == '0) ? LAST_IDX : back_idx_q - 1'b1;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.multi = (cnt_q > ONE_CNT);

  always_comb begin
    front_idx_d  = front_idx_q;
    back_idx_d   = back_idx_q;
    cnt_d        = cnt_q;
    front_val_d  = front_val_q;
    back_val_d   = back_val_q;
    fetch_back_d = fetch_back_q;
    wr_en        = 1'b0;
    wr_addr      = front_dec;
    rd_en        = 1'b0;
    rd_addr      = front_inc;

    if (cmd_i.push_front) begin
      front_idx_d = front_dec;
      wr_en       = 1'b1;
      wr_addr     = front_dec;
      cnt_d       = cnt_q + 1'b1;
      front_val_d = push_val;
      if (status_o.empty) begin
        back_val_d = push_val;
      end
    end else if (cmd_i.push_back) begin
      back_idx_d = back_inc;
      wr_en      = 1'b1;
      wr_addr    = back_inc;
      cnt_d      = cnt_q + 1'b1;
      back_val_d = push_val;
      if (status_o.empty) begin
        front_val_d = push_val;
      end
    end else if (cmd_i.pop_front) begin
      cnt_d = cnt_q - 1'b1;
      if (status_o.multi) begin
        front_idx_d  = front_inc;
        rd_en        = 1'b1;
        rd_addr      = front_inc;
        fetch_back_d = 1'b0;
      end else begin
        front_idx_d = '0;
        back_idx_d  = LAST_IDX;
      end
    end else if (cmd_i.pop_back) begin
      cnt_d = cnt_q - 1'b1;
      if (status_o.multi) begin
        back_idx_d   = back_dec;
        rd_en        = 1'b1;
        rd_addr      = back_dec;
        fetch_back_d = 1'b1;
      end else begin
        front_idx_d = '0;
        back_idx_d  = LAST_IDX;
      end
    end else if (cmd_i.clear) begin
      front_idx_d = '0;
      back_idx_d  = LAST_IDX;
      cnt_d       = '0;
    end else if (cmd_i.fetch) begin
      if (fetch_back_q) begin
        back_val_d = rd_data_q;
      end else begin
        front_val_d = rd_data_q;
      end
    end
  end

  assign empty_d = (cnt_d == '0);

  // slot memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= push_val;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      back_idx_q  <= LAST_IDX;
      cnt_q       <= '0;
    end else begin
      front_idx_q <= front_idx_d;
      back_idx_q  <= back_idx_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_val_q  <= front_val_d;
    back_val_q   <= back_val_d;
    fetch_back_q <= fetch_back_d;
    if (cmd_i.load_out) begin
      ok_q        <= cmd_i.ok;
      out_front_q <= empty_d ? '0 : VALUE_W'(front_val_d);
      out_back_q  <= empty_d ? '0 : VALUE_W'(back_val_d);
      out_cnt_q   <= COUNT_W'(cnt_d);
      out_empty_q <= empty_d;
    end
  end

  assign ok_o          = ok_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;
  assign entry_count_o = out_cnt_q;
  assign is_empty_o    = out_empty_q;

`ifndef SYNTHESIS
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("entry count beyond depth");

  a_empty_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> front_idx_q == '0 && back_idx_q == LAST_IDX)
    else $error("indexes not home while empty");

  a_one_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("memory read and write in the same cycle");
`endif

endmodule
